// ===== hw/rtl/ccb_pkg.sv =====
// ccb_pkg: shared types and constants for the clipped color-key blit core.
// Holds the register index codes, the queued pixel record and canvas defaults.
// No dependencies.
`default_nettype none

package ccb_pkg;

	// default canvas size
	localparam int unsigned CANVAS_WIDTH_DEF  = 384;
	localparam int unsigned CANVAS_HEIGHT_DEF = 216;

	// field widths fixed by the interface
	localparam int unsigned REG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 11;
	localparam int unsigned SIZE_W      = 11;
	localparam int unsigned COUNT_W     = 10;
	localparam int unsigned PIXEL_W     = 8;
	localparam int unsigned ADDR_W      = 17;

	// depth of the queue between front and back
	localparam int unsigned QUEUE_DEPTH = 2;

	// configuration register indexes
	typedef enum logic [REG_INDEX_W-1:0] {
		REG_SOURCE_WIDTH  = 3'd0,
		REG_SOURCE_HEIGHT = 3'd1,
		REG_DEST_X        = 3'd2,
		REG_DEST_Y        = 3'd3,
		REG_KEY_ENABLE    = 3'd4,
		REG_COLOR_KEY     = 3'd5
	} reg_index_t;

	// classified pixel handed from front to back
	typedef struct packed {
		logic [COUNT_W-1:0] cx;
		logic [COUNT_W-1:0] cy;
		logic [PIXEL_W-1:0] pixel;
		logic               we;
		logic               last;
	} item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/ccb_queue.sv =====
// ccb_queue: short register queue of classified pixels between front and back.
// Depends on ccb_pkg (item_t, QUEUE_DEPTH).
`default_nettype none

module ccb_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_en,
	input  wire ccb_pkg::item_t wr_item,
	output logic               full,
	input  wire logic          rd_en,
	output ccb_pkg::item_t     rd_item,
	output logic               empty
);
	import ccb_pkg::*;

	localparam int unsigned PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

	item_t            mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	// status
	assign full    = (count_q == CNT_FULL);
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_item = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

`ifndef SYNTHESIS
	// fill count never passes the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("queue count beyond depth");

	// a lone write grows the count by one
	a_write_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(do_wr && !do_rd) |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("queue write lost");

	// a lone read shrinks the count by one
	a_read_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(do_rd && !do_wr) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("queue read lost");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ccb_front.sv =====
// ccb_front: configuration registers, sprite column/row counters and pixel
// classification (clip against canvas, color key, last flag).
// Depends on ccb_pkg.
`default_nettype none

module ccb_front #(
	parameter int unsigned CANVAS_WIDTH  = ccb_pkg::CANVAS_WIDTH_DEF,
	parameter int unsigned CANVAS_HEIGHT = ccb_pkg::CANVAS_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [ccb_pkg::REG_INDEX_W-1:0]   cfg_index,
	input  wire logic [ccb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              push,
	input  wire logic [ccb_pkg::PIXEL_W-1:0]       source_pixel,
	output logic                                   accept,
	output ccb_pkg::item_t                         item
);
	import ccb_pkg::*;

	localparam logic signed [SIZE_W:0] CW_S = (SIZE_W+1)'(CANVAS_WIDTH);
	localparam logic signed [SIZE_W:0] CH_S = (SIZE_W+1)'(CANVAS_HEIGHT);
	localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(1024);
	localparam logic [SIZE_W-1:0] SIZE_MIN = SIZE_W'(1);

	logic [SIZE_W-1:0]        src_width_q;
	logic [SIZE_W-1:0]        src_height_q;
	logic [SIZE_W-1:0]        dest_x_q;
	logic [SIZE_W-1:0]        dest_y_q;
	logic                     key_enable_q;
	logic [PIXEL_W-1:0]       color_key_q;
	logic [COUNT_W-1:0]       column_q;
	logic [COUNT_W-1:0]       row_q;

	logic [SIZE_W-1:0]        width_eff;
	logic [SIZE_W-1:0]        height_eff;
	logic [SIZE_W-1:0]        column_inc;
	logic [SIZE_W-1:0]        row_inc;
	logic                     row_end;
	logic                     sprite_end;
	logic signed [SIZE_W:0]   cx;
	logic signed [SIZE_W:0]   cy;
	logic                     on_canvas;
	logic                     keyed;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q  <= SIZE_MIN;
			src_height_q <= SIZE_MIN;
			dest_x_q     <= '0;
			dest_y_q     <= '0;
			key_enable_q <= 1'b0;
			color_key_q  <= '0;
		end else if (cfg_write) begin
			case (reg_index_t'(cfg_index))
				REG_SOURCE_WIDTH:  src_width_q  <= cfg_data;
				REG_SOURCE_HEIGHT: src_height_q <= cfg_data;
				REG_DEST_X:        dest_x_q     <= cfg_data;
				REG_DEST_Y:        dest_y_q     <= cfg_data;
				REG_KEY_ENABLE:    key_enable_q <= cfg_data[0];
				REG_COLOR_KEY:     color_key_q  <= cfg_data[PIXEL_W-1:0];
				default: ;
			endcase
		end
	end

	// saturate sprite size to 1..1024
	always_comb begin
		if (src_width_q == '0) begin
			width_eff = SIZE_MIN;
		end else if (src_width_q > SIZE_MAX) begin
			width_eff = SIZE_MAX;
		end else begin
			width_eff = src_width_q;
		end
		if (src_height_q == '0) begin
			height_eff = SIZE_MIN;
		end else if (src_height_q > SIZE_MAX) begin
			height_eff = SIZE_MAX;
		end else begin
			height_eff = src_height_q;
		end
	end

	// row and sprite end detection
	assign column_inc = {1'b0, column_q} + SIZE_W'(1);
	assign row_inc    = {1'b0, row_q} + SIZE_W'(1);
	assign row_end    = (column_inc >= width_eff);
	assign sprite_end = row_end && (row_inc >= height_eff);

	// canvas position and clipping
	assign cx = $signed({dest_x_q[SIZE_W-1], dest_x_q}) + $signed({2'b00, column_q});
	assign cy = $signed({dest_y_q[SIZE_W-1], dest_y_q}) + $signed({2'b00, row_q});
	assign on_canvas = !cx[SIZE_W] && (cx < CW_S) && !cy[SIZE_W] && (cy < CH_S);
	assign keyed  = key_enable_q && (source_pixel == color_key_q);

	// classified pixel record
	always_comb begin
		item.cx    = cx[COUNT_W-1:0];
		item.cy    = cy[COUNT_W-1:0];
		item.pixel = source_pixel;
		item.we    = on_canvas && !keyed;
		item.last  = sprite_end;
	end

	assign accept = push;

	// sprite counters advance on every accepted beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q <= '0;
			row_q    <= '0;
		end else if (accept) begin
			if (row_end) begin
				column_q <= '0;
				row_q    <= sprite_end ? '0 : row_inc[COUNT_W-1:0];
			end else begin
				column_q <= column_inc[COUNT_W-1:0];
			end
		end
	end

`ifndef SYNTHESIS
	// the last pixel returns both counters to the origin
	a_last_wraps: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && sprite_end) |=> (column_q == '0 && row_q == '0))
		else $error("counters did not wrap after last pixel");

	// a written pixel always lies on the canvas
	a_we_on_canvas: assert property (@(posedge clk) disable iff (!arst_n)
		item.we |-> (!cx[SIZE_W] && !cy[SIZE_W] && (cx < CW_S) && (cy < CH_S)))
		else $error("write enable outside canvas");

	// counters hold while no beat is taken
	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> ($stable(column_q) && $stable(row_q)))
		else $error("counters moved without a beat");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/ccb_back.sv =====
// ccb_back: turns a classified pixel into a canvas address and holds the
// result in the output register until it is popped.
// Depends on ccb_pkg.
`default_nettype none

module ccb_back #(
	parameter int unsigned CANVAS_WIDTH = ccb_pkg::CANVAS_WIDTH_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire ccb_pkg::item_t                 item,
	input  wire logic                           item_avail,
	output logic                                item_take,
	output logic                                empty,
	input  wire logic                           pop,
	output logic [ccb_pkg::ADDR_W-1:0]          canvas_address,
	output logic [ccb_pkg::PIXEL_W-1:0]         pixel_value,
	output logic                                write_enable,
	output logic                                last_pixel
);
	import ccb_pkg::*;

	localparam int unsigned PROD_W = 2 * SIZE_W - 1;
	localparam logic [SIZE_W-1:0] CW_L = SIZE_W'(CANVAS_WIDTH);

	logic               out_valid_q;
	logic [ADDR_W-1:0]  addr_q;
	logic [PIXEL_W-1:0] pixel_q;
	logic               we_q;
	logic               last_q;
	logic [PROD_W-1:0]  row_base;
	logic [PROD_W-1:0]  linear;
	logic [ADDR_W-1:0]  addr_next;

	// row times canvas width plus column, zero when not written
	assign row_base  = PROD_W'(item.cy) * PROD_W'(CW_L);
	assign linear    = row_base + PROD_W'(item.cx);
	assign addr_next = item.we ? linear[ADDR_W-1:0] : '0;

	// take a new beat when the output register is free or being drained
	assign item_take = item_avail && (!out_valid_q || pop);

	// output valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (item_take) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (item_take) begin
			addr_q  <= addr_next;
			pixel_q <= item.pixel;
			we_q    <= item.we;
			last_q  <= item.last;
		end
	end

	assign empty          = !out_valid_q;
	assign canvas_address = addr_q;
	assign pixel_value    = pixel_q;
	assign write_enable   = we_q;
	assign last_pixel     = last_q;

`ifndef SYNTHESIS
	// a pixel that is not written carries address zero
	a_addr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !write_enable) |-> (canvas_address == '0))
		else $error("address not zero on unwritten pixel");

	// a beat is only taken from a non-empty queue
	a_take_avail: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |-> item_avail)
		else $error("took a beat from an empty queue");

	// a taken beat always shows on the output next cycle
	a_take_shows: assert property (@(posedge clk) disable iff (!arst_n)
		item_take |=> !empty)
		else $error("taken beat not presented");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/clipped_color_key_blit_core.sv =====
// clipped_color_key_blit_core: top level of the clipped color-key blitter.
// Instantiates ccb_front, ccb_queue and ccb_back; depends on ccb_pkg.
//
//   channel   ports                                      handshake
//   ------    -----------------------------------------  -------------------
//   config    cfg_write, cfg_index, cfg_data             write on cfg_write
//   pixel in  source_pixel                               push && !full
//   result    canvas_address, pixel_value,               pop && !empty
//             write_enable, last_pixel
//
// One pixel per cycle sustained while the result side keeps popping; each beat needs
// only counters, compares and one constant-width multiply in the back stage.
// An accepted pixel is written into the two-entry queue and then into the output
// register, from which it shows on the ports.
// A stalled result side fills the queue; full rises when it holds two beats.
// Reset is asynchronous and clears counters, queue and output valid; the
// configuration registers return to width 1, height 1, offset 0, keying off.
`default_nettype none

module clipped_color_key_blit_core #(
	parameter int unsigned CANVAS_WIDTH  = ccb_pkg::CANVAS_WIDTH_DEF,
	parameter int unsigned CANVAS_HEIGHT = ccb_pkg::CANVAS_HEIGHT_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [ccb_pkg::REG_INDEX_W-1:0]   cfg_index,
	input  wire logic [ccb_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic [ccb_pkg::PIXEL_W-1:0]       source_pixel,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [ccb_pkg::ADDR_W-1:0]             canvas_address,
	output logic [ccb_pkg::PIXEL_W-1:0]            pixel_value,
	output logic                                   write_enable,
	output logic                                   last_pixel
);
	import ccb_pkg::*;

	item_t front_item;
	item_t back_item;
	logic  front_push;
	logic  queue_full;
	logic  queue_empty;
	logic  back_take;
	logic  accept;

	assign full   = queue_full;
	assign accept = push && !queue_full;

	// front: config, counters, classification
	ccb_front #(
		.CANVAS_WIDTH  (CANVAS_WIDTH),
		.CANVAS_HEIGHT (CANVAS_HEIGHT)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.push         (accept),
		.source_pixel (source_pixel),
		.accept       (front_push),
		.item         (front_item)
	);

	// queue between front and back
	ccb_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (front_push),
		.wr_item (front_item),
		.full    (queue_full),
		.rd_en   (back_take),
		.rd_item (back_item),
		.empty   (queue_empty)
	);

	// back: address and output register
	ccb_back #(
		.CANVAS_WIDTH (CANVAS_WIDTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.item           (back_item),
		.item_avail     (!queue_empty),
		.item_take      (back_take),
		.empty          (empty),
		.pop            (pop),
		.canvas_address (canvas_address),
		.pixel_value    (pixel_value),
		.write_enable   (write_enable),
		.last_pixel     (last_pixel)
	);

endmodule

`default_nettype wire

// ===== sim/clipped_color_key_blit_core_tb.sv =====
// testbench for clipped_color_key_blit_core: directed table, then random sprite phases
// beats are checked against a self-contained blit predictor; depends on ccb_pkg and the rtl

module testbench;

	import ccb_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 12;
	localparam int CANVAS_W       = 384;
	localparam int CANVAS_H       = 216;
	localparam int RANDOM_ITEMS   = 650;
	localparam int HOLD_CYCLES    = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int END_CYCLES     = 10;
	localparam int MAX_PRINTED    = 40;

	// one result beat
	typedef struct packed {
		logic [ADDR_W-1:0]  addr;
		logic [PIXEL_W-1:0] pix;
		logic               we;
		logic               last;
	} blit_result_t;

	typedef enum logic {STEP_WRITE, STEP_PIXEL} step_kind_t;

	// one row of the directed table
	typedef struct packed {
		step_kind_t          kind;
		reg_index_t          index;
		logic [CFG_DATA_W-1:0] data;
		logic [PIXEL_W-1:0]  pixel;
		logic                fixed;
		blit_result_t        want;
	} blit_step_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_write;
	reg_index_t            cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  push;
	logic                  full;
	logic [PIXEL_W-1:0]    source_pixel;
	logic                  empty;
	logic                  pop;
	logic [ADDR_W-1:0]     canvas_address;
	logic [PIXEL_W-1:0]    pixel_value;
	logic                  write_enable;
	logic                  last_pixel;

	// predictor copy of the registers and the sprite counters
	logic [SIZE_W-1:0]        cfg_width  = 11'd1;
	logic [SIZE_W-1:0]        cfg_height = 11'd1;
	logic signed [SIZE_W-1:0] cfg_dest_x = '0;
	logic signed [SIZE_W-1:0] cfg_dest_y = '0;
	logic                     cfg_key_en = 1'b0;
	logic [PIXEL_W-1:0]       cfg_key    = '0;
	logic [COUNT_W-1:0]       sprite_col = '0;
	logic [COUNT_W-1:0]       sprite_row = '0;

	blit_result_t expected_beats[$];
	int error_count = 0;
	int no_accept_cycles = 0;
	int pressure_req = 0;
	bit no_idle = 1'b0;

	clipped_color_key_blit_core #(
		.CANVAS_WIDTH  (CANVAS_W),
		.CANVAS_HEIGHT (CANVAS_H)
	) dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.push           (push),
		.full           (full),
		.source_pixel   (source_pixel),
		.empty          (empty),
		.pop            (pop),
		.canvas_address (canvas_address),
		.pixel_value    (pixel_value),
		.write_enable   (write_enable),
		.last_pixel     (last_pixel)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// directed table: typed beats where the answer is obvious, predictor elsewhere
	localparam int NUM_STEPS = 35;
	blit_step_t directed_steps [NUM_STEPS] = '{
		// reset config: 1x1 sprite at the origin, keying off
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h00, 1'b1, '{17'd0, 8'h00, 1'b1, 1'b1}},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'hFF, 1'b1, '{17'd0, 8'hFF, 1'b1, 1'b1}},
		// keyed colour is dropped, anything else passes
		'{STEP_WRITE, REG_KEY_ENABLE,    11'd1,    8'h00, 1'b0, '0},
		'{STEP_WRITE, REG_COLOR_KEY,     11'hFF,   8'h00, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'hFF, 1'b1, '{17'd0, 8'hFF, 1'b0, 1'b1}},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'hFE, 1'b0, '0},
		'{STEP_WRITE, REG_COLOR_KEY,     11'h00,   8'h00, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h00, 1'b1, '{17'd0, 8'h00, 1'b0, 1'b1}},
		// bottom-right canvas corner, then one column past it
		'{STEP_WRITE, REG_DEST_X,        11'd383,  8'h00, 1'b0, '0},
		'{STEP_WRITE, REG_DEST_Y,        11'd215,  8'h00, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h5A, 1'b1, '{17'd82943, 8'h5A, 1'b1, 1'b1}},
		'{STEP_WRITE, REG_SOURCE_WIDTH,  11'd2,    8'h00, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h11, 1'b1, '{17'd82943, 8'h11, 1'b1, 1'b0}},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h22, 1'b1, '{17'd0, 8'h22, 1'b0, 1'b1}},
		// sprite entirely off canvas at the most negative offset
		'{STEP_WRITE, REG_DEST_X,        11'h400,  8'h00, 1'b0, '0},
		'{STEP_WRITE, REG_DEST_Y,        11'h400,  8'h00, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h33, 1'b1, '{17'd0, 8'h33, 1'b0, 1'b0}},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h44, 1'b1, '{17'd0, 8'h44, 1'b0, 1'b1}},
		// zero width acts as one, oversize height saturates, top row clipped
		'{STEP_WRITE, REG_SOURCE_WIDTH,  11'd0,    8'h00, 1'b0, '0},
		'{STEP_WRITE, REG_SOURCE_HEIGHT, 11'd2047, 8'h00, 1'b0, '0},
		'{STEP_WRITE, REG_DEST_X,        11'd0,    8'h00, 1'b0, '0},
		'{STEP_WRITE, REG_DEST_Y,        11'h7FF,  8'h00, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h55, 1'b1, '{17'd0, 8'h55, 1'b0, 1'b0}},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h66, 1'b1, '{17'd0, 8'h66, 1'b1, 1'b0}},
		// size shrinks under the counters mid-sprite
		'{STEP_WRITE, REG_SOURCE_WIDTH,  11'd4,    8'h00, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h77, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h88, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h99, 1'b0, '0},
		'{STEP_WRITE, REG_SOURCE_WIDTH,  11'd2,    8'h00, 1'b0, '0},
		'{STEP_WRITE, REG_SOURCE_HEIGHT, 11'd1,    8'h00, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'hAA, 1'b1, '{17'd387, 8'hAA, 1'b1, 1'b1}},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'hBB, 1'b1, '{17'd0, 8'hBB, 1'b0, 1'b0}},
		// keying off lets the key colour through
		'{STEP_WRITE, REG_KEY_ENABLE,    11'd0,    8'h00, 1'b0, '0},
		'{STEP_WRITE, REG_DEST_Y,        11'd0,    8'h00, 1'b0, '0},
		'{STEP_PIXEL, REG_SOURCE_WIDTH,  11'd0,    8'h00, 1'b1, '{17'd1, 8'h00, 1'b1, 1'b1}}
	};

	function automatic int clamp_size(input logic [SIZE_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > 1024)
			return 1024;
		return int'(v);
	endfunction

	// canvas placement of one pixel, advances the sprite counters
	function automatic blit_result_t predict_blit(input logic [PIXEL_W-1:0] pix);
		blit_result_t r;
		int w;
		int h;
		int cx;
		int cy;
		bit on_canvas;
		bit row_end;
		w = clamp_size(cfg_width);
		h = clamp_size(cfg_height);
		cx = int'(cfg_dest_x) + int'(sprite_col);
		cy = int'(cfg_dest_y) + int'(sprite_row);
		on_canvas = cx >= 0 && cx < CANVAS_W && cy >= 0 && cy < CANVAS_H;
		row_end = int'(sprite_col) + 1 >= w;
		r.pix = pix;
		r.we = on_canvas && !(cfg_key_en && pix == cfg_key);
		r.addr = r.we ? ADDR_W'(cy * CANVAS_W + cx) : '0;
		r.last = row_end && int'(sprite_row) + 1 >= h;
		if (row_end) begin
			sprite_col = '0;
			sprite_row = (int'(sprite_row) + 1 >= h) ? '0 : sprite_row + 1'b1;
		end else begin
			sprite_col = sprite_col + 1'b1;
		end
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int pick_gap();
		int r;
		if (no_idle)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return CFG_DATA_W'($urandom_range(1, 8));
		if (r < 80)
			return CFG_DATA_W'($urandom_range(9, 64));
		if (r < 90) begin
			case ($urandom_range(0, 4))
				0: return 11'd0;
				1: return 11'd1;
				2: return 11'd1024;
				3: return 11'd1025;
				default: return 11'd2047;
			endcase
		end
		return CFG_DATA_W'($urandom_range(65, 1024));
	endfunction

	function automatic logic [CFG_DATA_W-1:0] pick_offset(input int span);
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return CFG_DATA_W'(int'($urandom_range(0, span + 20)) - 10);
		if (r < 85) begin
			case ($urandom_range(0, 5))
				0: return 11'h400;
				1: return 11'h3FF;
				2: return 11'h7FF;
				3: return 11'd0;
				4: return CFG_DATA_W'(span - 1);
				default: return CFG_DATA_W'(span);
			endcase
		end
		return CFG_DATA_W'($urandom);
	endfunction

	task automatic report_mismatch(input string msg);
		error_count++;
		if (error_count <= MAX_PRINTED)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// register write, one beat followed by idle
	task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			REG_SOURCE_WIDTH:  cfg_width = data;
			REG_SOURCE_HEIGHT: cfg_height = data;
			REG_DEST_X:        cfg_dest_x = data;
			REG_DEST_Y:        cfg_dest_y = data;
			REG_KEY_ENABLE:    cfg_key_en = data[0];
			REG_COLOR_KEY:     cfg_key = data[PIXEL_W-1:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	// offer one pixel until accepted, then queue what it should produce
	task automatic send_pixel(input logic [PIXEL_W-1:0] pix, input bit fixed,
			input blit_result_t want);
		blit_result_t pred;
		push <= 1'b1;
		source_pixel <= pix;
		do @(posedge clk); while (full);
		pred = predict_blit(pix);
		expected_beats.push_back(fixed ? want : pred);
	endtask

	task automatic idle_sender();
		int n;
		n = pick_gap();
		if (n > 0) begin
			push <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// stop offering and wait for every expected beat
	task automatic drain_results();
		push <= 1'b0;
		@(posedge clk);
		while (expected_beats.size() != 0)
			@(posedge clk);
	endtask

	// stimulus
	initial begin : stimulus
		int sent;
		int phase;
		int w;
		int h;
		int left;
		int n;
		bit pressure;
		logic [PIXEL_W-1:0] pix;
		sent = 0;
		phase = 0;
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_index = REG_SOURCE_WIDTH;
		cfg_data = '0;
		push = 1'b0;
		source_pixel = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_steps[i]) begin
			if (directed_steps[i].kind == STEP_WRITE) begin
				drain_results();
				write_reg(directed_steps[i].index, directed_steps[i].data);
			end else begin
				send_pixel(directed_steps[i].pixel, directed_steps[i].fixed,
					directed_steps[i].want);
				idle_sender();
			end
		end

		// random phases: new settings, then mostly whole sprites
		while (sent < RANDOM_ITEMS) begin
			drain_results();
			pressure = (phase == 2) || ($urandom_range(0, 11) == 0);
			no_idle = pressure || ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 1))
				write_reg(REG_SOURCE_WIDTH, pick_size());
			if ($urandom_range(0, 1))
				write_reg(REG_SOURCE_HEIGHT, pick_size());
			if ($urandom_range(0, 1))
				write_reg(REG_DEST_X, pick_offset(CANVAS_W));
			if ($urandom_range(0, 1))
				write_reg(REG_DEST_Y, pick_offset(CANVAS_H));
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_KEY_ENABLE, CFG_DATA_W'($urandom));
			if ($urandom_range(0, 2) == 0)
				write_reg(REG_COLOR_KEY, CFG_DATA_W'($urandom));
			w = clamp_size(cfg_width);
			h = clamp_size(cfg_height);
			left = w * h - (int'(sprite_row) * w + int'(sprite_col));
			if (left < 1)
				left = 1;
			if ($urandom_range(0, 3) != 0)
				n = left + w * h * $urandom_range(0, 2);
			else
				n = $urandom_range(1, 20);
			if (n > 48)
				n = $urandom_range(16, 48);
			if (pressure) begin
				n = (n < 40) ? 40 : n;
				pressure_req++;
			end
			repeat (n) begin
				if (cfg_key_en && $urandom_range(0, 3) == 0)
					pix = cfg_key;
				else
					pix = PIXEL_W'($urandom);
				send_pixel(pix, 1'b0, '0);
				sent++;
				idle_sender();
			end
			phase++;
		end

		// wind down
		no_idle = 1'b0;
		drain_results();
		repeat (END_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// result side: random stalls plus a long hold-off on request
	initial begin : result_sink
		int stall;
		int served;
		stall = 0;
		served = 0;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (pressure_req != served) begin
				served = pressure_req;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				pop <= 1'b0;
				stall--;
			end else begin
				pop <= 1'b1;
				stall = pick_gap();
			end
		end
	end

	// compare each popped beat against the oldest expectation
	always @(posedge clk) begin : beat_check
		blit_result_t want;
		if (arst_n && pop && !empty) begin
			if (expected_beats.size() == 0) begin
				report_mismatch($sformatf("unexpected beat addr=%0d pix=%02h we=%b last=%b",
					canvas_address, pixel_value, write_enable, last_pixel));
			end else begin
				want = expected_beats.pop_front();
				if (canvas_address !== want.addr)
					report_mismatch($sformatf("canvas_address %0d, expected %0d",
						canvas_address, want.addr));
				if (pixel_value !== want.pix)
					report_mismatch($sformatf("pixel_value %02h, expected %02h",
						pixel_value, want.pix));
				if (write_enable !== want.we)
					report_mismatch($sformatf("write_enable %b, expected %b",
						write_enable, want.we));
				if (last_pixel !== want.last)
					report_mismatch($sformatf("last_pixel %b, expected %b",
						last_pixel, want.last));
			end
		end
	end

	// watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if ((push && !full) || (pop && !empty))
			no_accept_cycles <= 0;
		else
			no_accept_cycles <= no_accept_cycles + 1;
		if (no_accept_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end
	end

endmodule
